/* hw/rtl/kss_pkg.sv */
// Package for the KPI stream statistics block: word types, codes and defaults.
// No dependencies; every other file of the block imports it.
package kss_pkg;

  localparam int unsigned CountBitsDef = 20;
  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned NumMetrics   = 5;

  // input word kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_REPORT  = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // configuration register indexes
  localparam logic [3:0] REG_CPU_THR  = 4'd0;
  localparam logic [3:0] REG_MEM_THR  = 4'd1;
  localparam logic [3:0] REG_LAT_THR  = 4'd2;
  localparam logic [3:0] REG_LOSS_THR = 4'd3;

  // metric codes
  localparam logic [2:0] MET_CPU  = 3'd0;
  localparam logic [2:0] MET_MEM  = 3'd1;
  localparam logic [2:0] MET_LAT  = 3'd2;
  localparam logic [2:0] MET_THR  = 3'd3;
  localparam logic [2:0] MET_LOSS = 3'd4;

  localparam logic [13:0] CpuThrRst  = 14'd9000;
  localparam logic [13:0] MemThrRst  = 14'd9000;
  localparam logic [15:0] LatThrRst  = 16'd100;
  localparam logic [15:0] LossThrRst = 16'd5;

  typedef enum logic {ARITH_MUL, ARITH_DIV} kss_op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rec_id;
    logic [31:0] stamp;
    logic [15:0] latency_ms;
    logic [15:0] loss_val;
    logic [31:0] throughput_bps;
    logic [13:0] cpu_centi_pct;
    logic [13:0] mem_centi_pct;
  } kss_item_t;

  typedef struct packed {
    logic [2:0]  metric;
    logic [19:0] sample_count;
    logic [31:0] minimum;
    logic [31:0] maximum;
    logic [31:0] peak_record;
    logic [31:0] peak_stamp;
    logic [31:0] mean;
    logic [63:0] variance;
    logic [19:0] alert_count;
    logic        empty_res;
    logic        overflowed;
    logic        last;
  } kss_result_t;

  typedef struct packed {
    logic clr;
    logic sq_en;
    logic upd;
    logic first;
  } kss_lane_ctrl_t;

endpackage

/* hw/rtl/kss_lane.sv */
// One metric lane: value sum, with min/max, peak record and sum of squares if HAS_RANGE, alert count if HAS_ALERT.
// Depends on kss_pkg.
module kss_lane #(
  parameter int unsigned VALUE_BITS = kss_pkg::ValueBitsDef,
  parameter int unsigned COUNT_BITS = kss_pkg::CountBitsDef,
  parameter bit          HAS_RANGE  = 1'b1,
  parameter bit          HAS_ALERT  = 1'b1
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  kss_pkg::kss_lane_ctrl_t                   ctrl_i,
  input  logic [VALUE_BITS-1:0]                     value_i,
  input  logic [VALUE_BITS-1:0]                     limit_i,
  input  logic [31:0]                               record_i,
  input  logic [31:0]                               stamp_i,
  output logic [VALUE_BITS-1:0]                     min_o,
  output logic [VALUE_BITS-1:0]                     max_o,
  output logic [31:0]                               pid_o,
  output logic [31:0]                               pst_o,
  output logic [VALUE_BITS+COUNT_BITS-1:0]          sum_o,
  output logic [2*VALUE_BITS+COUNT_BITS-1:0]        sq_o,
  output logic [COUNT_BITS-1:0]                     alert_o
);
  import kss_pkg::*;

  localparam int unsigned SumW = VALUE_BITS + COUNT_BITS;
  localparam int unsigned SqW  = 2 * VALUE_BITS + COUNT_BITS;

  logic [SumW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clr) begin
      sum_q <= '0;
    end else if (ctrl_i.upd) begin
      sum_q <= sum_q + SumW'(value_i);
    end
  end
  assign sum_o = sum_q;

  if (HAS_RANGE) begin : g_range
    logic [2*VALUE_BITS-1:0] sqr_q;
    logic [SqW-1:0]          sqs_q;
    logic [VALUE_BITS-1:0]   min_q, max_q;
    logic [31:0]             pid_q, pst_q;

    // square is registered in the cycle before the accumulate
    always_ff @(posedge clk_i) begin
      if (ctrl_i.sq_en) begin
        sqr_q <= (2*VALUE_BITS)'(value_i) * (2*VALUE_BITS)'(value_i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqs_q <= '0;
        min_q <= '0;
        max_q <= '0;
        pid_q <= '0;
        pst_q <= '0;
      end else if (ctrl_i.clr) begin
        sqs_q <= '0;
        min_q <= '0;
        max_q <= '0;
        pid_q <= '0;
        pst_q <= '0;
      end else if (ctrl_i.upd) begin
        sqs_q <= sqs_q + SqW'(sqr_q);
        if (ctrl_i.first || value_i > max_q) begin
          max_q <= value_i;
          pid_q <= record_i;
          pst_q <= stamp_i;
        end
        if (ctrl_i.first || value_i < min_q) begin
          min_q <= value_i;
        end
      end
    end
    assign sq_o  = sqs_q;
    assign min_o = min_q;
    assign max_o = max_q;
    assign pid_o = pid_q;
    assign pst_o = pst_q;
  end else begin : g_norange
    assign sq_o  = '0;
    assign min_o = '0;
    assign max_o = '0;
    assign pid_o = '0;
    assign pst_o = '0;
  end

  if (HAS_ALERT) begin : g_alert
    logic [COUNT_BITS-1:0] alert_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        alert_q <= '0;
      end else if (ctrl_i.clr) begin
        alert_q <= '0;
      end else if (ctrl_i.upd && value_i > limit_i) begin
        alert_q <= alert_q + 1'b1;
      end
    end
    assign alert_o = alert_q;
  end else begin : g_noalert
    assign alert_o = '0;
  end

endmodule

/* hw/rtl/kss_arith.sv */
// Shared serial arithmetic unit: MSB-first shift-add multiply and restoring divide.
// Depends on kss_pkg.
module kss_arith #(
  parameter int unsigned NUMW = 104,
  parameter int unsigned MULW = 52,
  parameter int unsigned DENW = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  kss_pkg::kss_op_e op_i,
  input  logic [NUMW-1:0]  a_i,
  input  logic [NUMW-1:0]  b_i,
  output logic             busy_o,
  output logic [NUMW-1:0]  res_o
);
  import kss_pkg::*;

  localparam int unsigned CntW = $clog2(NUMW + 1);

  logic            busy_q;
  kss_op_e         op_q;
  logic [CntW-1:0] cnt_q;
  logic [NUMW-1:0] acc_q, sh_q, opnd_q;
  logic [DENW-1:0] rem_q;

  logic [DENW:0]   rem_sh, dv, rem_sub;
  logic            ge;

  assign rem_sh  = {rem_q, sh_q[NUMW-1]};
  assign dv      = {1'b0, opnd_q[DENW-1:0]};
  assign ge      = rem_sh >= dv;
  assign rem_sub = rem_sh - dv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ARITH_MUL;
    end else if (start_i) begin
      busy_q <= 1'b1;
      op_q   <= op_i;
      cnt_q  <= (op_i == ARITH_MUL) ? CntW'(MULW) : CntW'(NUMW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      rem_q <= '0;
      if (op_i == ARITH_MUL) begin
        sh_q   <= b_i << (NUMW - MULW);
        opnd_q <= a_i;
      end else begin
        sh_q   <= a_i;
        opnd_q <= b_i;
      end
    end else if (busy_q) begin
      sh_q <= sh_q << 1;
      if (op_q == ARITH_MUL) begin
        acc_q <= (acc_q << 1) + (sh_q[NUMW-1] ? opnd_q : '0);
      end else begin
        acc_q <= {acc_q[NUMW-2:0], ge};
        rem_q <= ge ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
      end
    end
  end

  assign busy_o = busy_q;
  assign res_o  = acc_q;

endmodule

/* hw/rtl/kss_report.sv */
// Report sequencer: merges the lane statistics into five result words per report,
// computing mean and variance on the shared serial unit. Depends on kss_pkg, kss_arith.
module kss_report #(
  parameter int unsigned VALUE_BITS = kss_pkg::ValueBitsDef,
  parameter int unsigned COUNT_BITS = kss_pkg::CountBitsDef
) (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    start_i,
  output logic                                                    busy_o,
  input  logic [COUNT_BITS-1:0]                                   count_i,
  input  logic                                                    drop_i,
  input  logic [kss_pkg::NumMetrics-1:0][VALUE_BITS-1:0]          min_i,
  input  logic [kss_pkg::NumMetrics-1:0][VALUE_BITS-1:0]          max_i,
  input  logic [kss_pkg::NumMetrics-1:0][31:0]                    pid_i,
  input  logic [kss_pkg::NumMetrics-1:0][31:0]                    pst_i,
  input  logic [kss_pkg::NumMetrics-1:0][VALUE_BITS+COUNT_BITS-1:0] sum_i,
  input  logic [kss_pkg::NumMetrics-1:0][2*VALUE_BITS+COUNT_BITS-1:0] sq_i,
  input  logic [kss_pkg::NumMetrics-1:0][COUNT_BITS-1:0]          alert_i,
  output logic                                                    out_valid_o,
  input  logic                                                    out_ready_i,
  output kss_pkg::kss_result_t                                    out_data_o
);
  import kss_pkg::*;

  localparam int unsigned SumW = VALUE_BITS + COUNT_BITS;
  localparam int unsigned NumW = 2 * SumW;
  localparam int unsigned DenW = 2 * COUNT_BITS;

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_N2   = 3'd1;
  localparam logic [2:0] R_MEAN = 3'd2;
  localparam logic [2:0] R_SQ   = 3'd3;
  localparam logic [2:0] R_NS   = 3'd4;
  localparam logic [2:0] R_VAR  = 3'd5;
  localparam logic [2:0] R_EMIT = 3'd6;

  logic [2:0]      state_q;
  logic [2:0]      m_q;
  logic            issued_q;
  logic            out_valid_q;
  kss_result_t     out_q, res;
  logic [DenW-1:0] n2_q;
  logic [31:0]     mean_q;
  logic [NumW-1:0] p_q, num_q;
  logic [63:0]     var_q;

  logic            ar_start, ar_busy, ar_done;
  kss_op_e         ar_op;
  logic [NumW-1:0] ar_a, ar_b, ar_res;
  logic [NumW+63:0] q_ext;
  logic            empty;

  kss_arith #(.NUMW(NumW), .MULW(SumW), .DENW(DenW)) u_arith (
    .clk_i, .rst_ni,
    .start_i(ar_start), .op_i(ar_op), .a_i(ar_a), .b_i(ar_b),
    .busy_o(ar_busy), .res_o(ar_res)
  );

  assign ar_done  = issued_q && !ar_busy;
  assign ar_start = !issued_q && (state_q == R_N2 || state_q == R_MEAN || state_q == R_SQ ||
                                  state_q == R_NS || state_q == R_VAR);
  assign empty    = (count_i == '0);
  assign q_ext    = {64'd0, ar_res};

  always_comb begin
    ar_op = ARITH_MUL;
    ar_a  = '0;
    ar_b  = '0;
    unique case (state_q)
      R_N2: begin
        ar_a = NumW'(count_i);
        ar_b = NumW'(count_i);
      end
      R_MEAN: begin
        ar_op = ARITH_DIV;
        ar_a  = NumW'(sum_i[m_q]);
        ar_b  = NumW'(count_i);
      end
      R_SQ: begin
        ar_a = NumW'(sum_i[m_q]);
        ar_b = NumW'(sum_i[m_q]);
      end
      R_NS: begin
        ar_a = NumW'(sq_i[m_q]);
        ar_b = NumW'(count_i);
      end
      R_VAR: begin
        ar_op = ARITH_DIV;
        ar_a  = num_q;
        ar_b  = NumW'(n2_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    res              = '0;
    res.metric       = m_q;
    res.overflowed   = drop_i;
    res.last         = (m_q == MET_LOSS);
    res.empty_res    = empty;
    if (!empty) begin
      res.sample_count = 20'(count_i);
      res.mean         = mean_q;
      res.alert_count  = 20'(alert_i[m_q]);
      if (m_q != MET_LOSS) begin
        res.minimum     = 32'(min_i[m_q]);
        res.maximum     = 32'(max_i[m_q]);
        res.peak_record = pid_i[m_q];
        res.peak_stamp  = pst_i[m_q];
        res.variance    = var_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= R_IDLE;
      m_q         <= MET_CPU;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ar_start) begin
        issued_q <= 1'b1;
      end else if (ar_done) begin
        issued_q <= 1'b0;
      end
      unique case (state_q)
        R_IDLE: begin
          if (start_i) begin
            m_q     <= MET_CPU;
            state_q <= empty ? R_EMIT : R_N2;
          end
        end
        R_N2:   if (ar_done) state_q <= R_MEAN;
        R_MEAN: if (ar_done) state_q <= (m_q == MET_LOSS) ? R_EMIT : R_SQ;
        R_SQ:   if (ar_done) state_q <= R_NS;
        R_NS:   if (ar_done) state_q <= R_VAR;
        R_VAR:  if (ar_done) state_q <= R_EMIT;
        R_EMIT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (m_q == MET_LOSS) begin
              state_q <= R_IDLE;
            end else begin
              m_q     <= m_q + 1'b1;
              state_q <= empty ? R_EMIT : R_MEAN;
            end
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ar_done) begin
      unique case (state_q)
        R_N2:   n2_q   <= ar_res[DenW-1:0];
        R_MEAN: mean_q <= ar_res[31:0];
        R_SQ:   p_q    <= ar_res;
        R_NS:   num_q  <= ar_res - p_q;
        R_VAR:  var_q  <= (|q_ext[NumW+63:64]) ? '1 : q_ext[63:0];
        default: ;
      endcase
    end
    if (state_q == R_EMIT && !out_valid_q) begin
      out_q <= res;
    end
  end

  assign busy_o      = (state_q != R_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/kpi_stream_statistics.sv */
// KPI stream statistics, top level: input sequencer, configuration registers,
// five metric lanes and the report merger. Depends on kss_pkg, kss_lane, kss_report.
//
// Usage: input words arrive on in_valid_i/in_ready_o with a kss_item_t payload.
// A sample word passes through capture, square and accumulate into all five
// lanes at once; the next word is taken when the sequencer is back in idle.
// A clear word is handled in idle, and a word of unknown kind is dropped there.
// A report word yields five result words on out_valid_o/out_ready_i, metric
// 0 to 4, last set on the fifth. With samples present the shared serial
// multiply/divide unit sets the report time: it computes n*n once, then for
// each non-loss metric the mean, sum squared, n*sumsq and variance before the
// word goes out, and for packet loss only the mean. An empty report skips
// the arithmetic and sends its five words directly.
// Each result word waits in an output register while the receiver stalls;
// no input is taken until the report unit and the sequencer are idle again.
// Configuration writes (cfg_valid_i, index, data) are taken every cycle and
// are meant to happen while the block is idle.
// Reset clears all statistics and loads the default alert limits.
module kpi_stream_statistics #(
  parameter int unsigned COUNT_BITS = kss_pkg::CountBitsDef,
  parameter int unsigned VALUE_BITS = kss_pkg::ValueBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kss_pkg::kss_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kss_pkg::kss_result_t out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [3:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import kss_pkg::*;

  localparam int unsigned SumW = VALUE_BITS + COUNT_BITS;
  localparam int unsigned SqW  = 2 * VALUE_BITS + COUNT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_RPT  = 2'd3;

  logic [1:0]            state_q;
  kss_item_t             item_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  drop_q;
  logic [13:0]           cpu_thr_q, mem_thr_q;
  logic [15:0]           lat_thr_q, loss_thr_q;

  logic                  in_acc, rpt_start, rpt_busy;
  kss_lane_ctrl_t        ctrl;

  logic [NumMetrics-1:0][VALUE_BITS-1:0] vals, lims, min_w, max_w;
  logic [NumMetrics-1:0][31:0]           pid_w, pst_w;
  logic [NumMetrics-1:0][SumW-1:0]       sum_w;
  logic [NumMetrics-1:0][SqW-1:0]        sq_w;
  logic [NumMetrics-1:0][COUNT_BITS-1:0] alert_w;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign rpt_start   = in_acc && (in_data_i.kind == KIND_REPORT);
  assign cfg_ready_o = 1'b1;

  assign ctrl.clr   = in_acc && (in_data_i.kind == KIND_CLEAR);
  assign ctrl.sq_en = (state_q == ST_SQ);
  assign ctrl.upd   = (state_q == ST_ACC);
  assign ctrl.first = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_thr_q  <= CpuThrRst;
      mem_thr_q  <= MemThrRst;
      lat_thr_q  <= LatThrRst;
      loss_thr_q <= LossThrRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CPU_THR:  cpu_thr_q  <= cfg_data_i[13:0];
        REG_MEM_THR:  mem_thr_q  <= cfg_data_i[13:0];
        REG_LAT_THR:  lat_thr_q  <= cfg_data_i;
        REG_LOSS_THR: loss_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_data_i.kind)
              KIND_SAMPLE: begin
                // full count: sample is dropped and flagged
                if (cnt_q == '1) drop_q <= 1'b1;
                else             state_q <= ST_SQ;
              end
              KIND_REPORT: state_q <= ST_RPT;
              KIND_CLEAR: begin
                cnt_q  <= '0;
                drop_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_SQ:  state_q <= ST_ACC;
        ST_ACC: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= ST_IDLE;
        end
        ST_RPT: if (!rpt_busy) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign vals[MET_CPU]  = VALUE_BITS'(item_q.cpu_centi_pct);
  assign vals[MET_MEM]  = VALUE_BITS'(item_q.mem_centi_pct);
  assign vals[MET_LAT]  = VALUE_BITS'(item_q.latency_ms);
  assign vals[MET_THR]  = item_q.throughput_bps[VALUE_BITS-1:0];
  assign vals[MET_LOSS] = VALUE_BITS'(item_q.loss_val);

  assign lims[MET_CPU]  = VALUE_BITS'(cpu_thr_q);
  assign lims[MET_MEM]  = VALUE_BITS'(mem_thr_q);
  assign lims[MET_LAT]  = VALUE_BITS'(lat_thr_q);
  assign lims[MET_THR]  = '0;
  assign lims[MET_LOSS] = VALUE_BITS'(loss_thr_q);

  for (genvar g = 0; g < NumMetrics; g++) begin : g_lane
    kss_lane #(
      .VALUE_BITS(VALUE_BITS),
      .COUNT_BITS(COUNT_BITS),
      .HAS_RANGE (g != MET_LOSS),
      .HAS_ALERT (g != MET_THR)
    ) u_lane (
      .clk_i, .rst_ni,
      .ctrl_i  (ctrl),
      .value_i (vals[g]),
      .limit_i (lims[g]),
      .record_i(item_q.rec_id),
      .stamp_i (item_q.stamp),
      .min_o   (min_w[g]),
      .max_o   (max_w[g]),
      .pid_o   (pid_w[g]),
      .pst_o   (pst_w[g]),
      .sum_o   (sum_w[g]),
      .sq_o    (sq_w[g]),
      .alert_o (alert_w[g])
    );
  end

  kss_report #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) u_report (
    .clk_i, .rst_ni,
    .start_i    (rpt_start),
    .busy_o     (rpt_busy),
    .count_i    (cnt_q),
    .drop_i     (drop_q),
    .min_i      (min_w),
    .max_i      (max_w),
    .pid_i      (pid_w),
    .pst_i      (pst_w),
    .sum_i      (sum_w),
    .sq_i       (sq_w),
    .alert_i    (alert_w),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
